/* rtl/calendar_clock_rollover_unit_macros.svh */
// Assertion macros shared by the calendar clock checker.
`ifndef CALENDAR_CLOCK_ROLLOVER_UNIT_MACROS_SVH
`define CALENDAR_CLOCK_ROLLOVER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CCR_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is high.
`define CCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

/* rtl/ccr_pkg.sv */
// Package with the types and constants of the calendar clock rollover unit.
package ccr_pkg;

  // Request kinds carried in tuser.
  typedef enum logic {
    ReqAdvance = 1'b0,
    ReqLoad    = 1'b1
  } req_kind_t;

  // Month numbers that the day rollover rules test against.
  localparam logic [3:0] MonthFeb = 4'd2;
  localparam logic [3:0] MonthMar = 4'd3;
  localparam logic [3:0] MonthApr = 4'd4;
  localparam logic [3:0] MonthJun = 4'd6;
  localparam logic [3:0] MonthSep = 4'd9;
  localparam logic [3:0] MonthNov = 4'd11;
  localparam logic [4:0] MonthsPerYear = 5'd12;

  // Carry limits.
  localparam logic [10:0] MsPerSec    = 11'd1000;
  localparam logic [10:0] MsTwoSec    = 11'd2000;
  localparam logic [6:0]  SecPerMin   = 7'd60;
  localparam logic [6:0]  MinPerHour  = 7'd60;
  localparam logic [5:0]  HourPerDay  = 6'd24;
  localparam logic [6:0]  DayLeapFeb  = 7'd29;
  localparam logic [6:0]  DayEndFeb   = 7'd30;
  localparam logic [6:0]  DayEndShort = 7'd31;
  localparam logic [6:0]  DayOverflow = 7'd32;

  // Stream payload widths.
  localparam int unsigned DataWidth = 56;

  // One request after unpacking.
  typedef struct packed {
    req_kind_t   kind;
    logic [9:0]  elapsed_ms;
    logic [5:0]  load_second;
    logic [5:0]  load_minute;
    logic [4:0]  load_hour;
    logic [4:0]  load_day;
    logic [3:0]  load_month;
    logic [15:0] load_year;
  } req_t;

  // Calendar time state; the day keeps six bits as the counter does.
  typedef struct packed {
    logic [9:0]  millis;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [5:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
  } time_t;

endpackage

/* rtl/ccr_step.sv */
// Combinational next-time logic: load, or advance with the carry cascade.
module ccr_step (
  input  ccr_pkg::req_t  req,
  input  ccr_pkg::time_t cur,
  output ccr_pkg::time_t nxt
);
  import ccr_pkg::*;

  logic [10:0] ms_sum;
  logic        ms_c1;
  logic        ms_c2;
  logic [1:0]  sec_carry;
  logic [6:0]  sec_sum;
  logic        sec_wrap;
  logic [6:0]  min_sum;
  logic        min_wrap;
  logic [5:0]  hour_sum;
  logic        hour_wrap;
  logic [6:0]  day_sum;
  logic [4:0]  month_sum;
  logic        roll_feb;
  logic        roll_short;
  logic        roll_over;
  logic        year_wrap;
  time_t       adv;

  // Advance path: every field of the advanced time is built in this one block.
  always_comb begin
    // Millisecond accumulator: at most two whole seconds come out of one advance.
    ms_sum    = {1'b0, cur.millis} + {1'b0, req.elapsed_ms};
    ms_c2     = (ms_sum >= MsTwoSec);
    ms_c1     = (ms_sum >= MsPerSec);
    sec_carry = ms_c2 ? 2'd2 : (ms_c1 ? 2'd1 : 2'd0);
    if (ms_c2) begin
      adv.millis = 10'(ms_sum - MsTwoSec);
    end else if (ms_c1) begin
      adv.millis = 10'(ms_sum - MsPerSec);
    end else begin
      adv.millis = ms_sum[9:0];
    end

    // Seconds, minutes and hours each carry at most once.
    sec_sum    = {1'b0, cur.second} + {5'd0, sec_carry};
    sec_wrap   = ms_c1 && (sec_sum >= SecPerMin);
    adv.second = sec_wrap ? 6'(sec_sum - SecPerMin) : sec_sum[5:0];

    min_sum    = {1'b0, cur.minute} + {6'd0, sec_wrap};
    min_wrap   = sec_wrap && (min_sum >= MinPerHour);
    adv.minute = min_wrap ? 6'(min_sum - MinPerHour) : min_sum[5:0];

    hour_sum   = {1'b0, cur.hour} + {5'd0, min_wrap};
    hour_wrap  = min_wrap && (hour_sum >= HourPerDay);
    adv.hour   = hour_wrap ? 5'(hour_sum - HourPerDay) : hour_sum[4:0];

    // Day of month rollover against the month length table.
    day_sum    = {1'b0, cur.day} + 7'd1;
    month_sum  = {1'b0, cur.month} + 5'd1;
    roll_feb   = (cur.month == MonthFeb) &&
                 ((day_sum == DayEndFeb) ||
                  ((day_sum == DayLeapFeb) && (cur.year[1:0] != 2'd0)));
    roll_short = (day_sum == DayEndShort) &&
                 (cur.month inside {MonthApr, MonthJun, MonthSep, MonthNov});
    roll_over  = (day_sum >= DayOverflow);
    year_wrap  = hour_wrap && roll_over && (month_sum > MonthsPerYear);

    adv.day   = cur.day;
    adv.month = cur.month;
    adv.year  = cur.year;
    if (hour_wrap) begin
      if (roll_feb) begin
        adv.day   = 6'd1;
        adv.month = MonthMar;
      end else if (roll_short) begin
        adv.day   = 6'd1;
        adv.month = month_sum[3:0];
      end else if (roll_over) begin
        adv.day   = 6'd1;
        adv.month = (month_sum > MonthsPerYear) ? 4'd1 : month_sum[3:0];
      end else begin
        adv.day   = day_sum[5:0];
      end
    end
    if (year_wrap) begin
      adv.year = cur.year + 16'd1;
    end
  end

  // Load writes every field and clears the accumulator.
  always_comb begin
    case (req.kind)
      ReqLoad: begin
        nxt.millis = 10'd0;
        nxt.second = req.load_second;
        nxt.minute = req.load_minute;
        nxt.hour   = req.load_hour;
        nxt.day    = {1'b0, req.load_day};
        nxt.month  = req.load_month;
        nxt.year   = req.load_year;
      end
      default: begin
        nxt = adv;
      end
    endcase
  end

endmodule

/* rtl/calendar_clock_rollover_unit.sv */
// Top level of the calendar clock rollover unit: request register, time state.
//
//  Channel | Direction | Transaction                 | tuser    | tdata (56 bits)
//  s_*     | in        | advance or load request     | req_type | elapsed/load fields
//  m_*     | out       | current time after request  | none     | millis .. year
//
//  Each request passes from input to output through the request register and then
//  through the carry cascade into the time registers, which drive m_tdata.
//  A new request is taken every cycle while the output side keeps up.
//  Reset is synchronous; it clears both valid flags and sets 00:00:00, day 1,
//  month 1, year 0.
//  A stalled output holds the time; the request register fills, then s_tready drops.
module calendar_clock_rollover_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // Fields from bit 0: elapsed_ms[9:0], load_second[15:10], load_minute[21:16],
  // load_hour[26:22], load_day[31:27], load_month[35:32], load_year[51:36], zero fill.
  input  logic [ccr_pkg::DataWidth-1:0]  s_tdata,
  // Fields from bit 0: req_type.
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // Fields from bit 0: millis[9:0], second[15:10], minute[21:16], hour[26:22],
  // day[31:27], month[35:32], year[51:36], zero fill.
  output logic [ccr_pkg::DataWidth-1:0]  m_tdata
);
  import ccr_pkg::*;

  logic  req_valid;
  req_t  req;
  logic  out_valid;
  time_t state;
  time_t state_next;
  req_t  req_in;
  logic  advance;

  // Unpack the incoming transaction.
  always_comb begin
    req_in.kind        = req_kind_t'(s_tuser);
    req_in.elapsed_ms  = s_tdata[9:0];
    req_in.load_second = s_tdata[15:10];
    req_in.load_minute = s_tdata[21:16];
    req_in.load_hour   = s_tdata[26:22];
    req_in.load_day    = s_tdata[31:27];
    req_in.load_month  = s_tdata[35:32];
    req_in.load_year   = s_tdata[51:36];
  end

  // The pipeline moves when the output is empty or being taken.
  assign advance  = !out_valid || m_tready;
  assign s_tready = !req_valid || advance;

  // Request register.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      req_valid <= 1'b1;
    end else if (advance) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req <= req_in;
    end
  end

  // Next time from the registered request.
  ccr_step u_step (
    .req (req),
    .cur (state),
    .nxt (state_next)
  );

  // Time state doubles as the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      state.millis <= 10'd0;
      state.second <= 6'd0;
      state.minute <= 6'd0;
      state.hour   <= 5'd0;
      state.day    <= 6'd1;
      state.month  <= 4'd1;
      state.year   <= 16'd0;
    end else if (advance) begin
      out_valid <= req_valid;
      if (req_valid) begin
        state <= state_next;
      end
    end
  end

  // Pack the result transaction.
  assign m_tvalid = out_valid;
  assign m_tdata  = {4'd0, state.year, state.month, state.day[4:0], state.hour,
                     state.minute, state.second, state.millis};

endmodule

/* rtl/ccr_checker.sv */
// Port-level checker for the calendar clock rollover unit, bound to the top level.
`include "calendar_clock_rollover_unit_macros.svh"

module ccr_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [ccr_pkg::DataWidth-1:0] m_tdata
);

  logic in_xfer;

  assign in_xfer = s_tvalid && s_tready;

  // A waiting result holds its value.
  `CCR_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // The millisecond field always stays below one second.
  `CCR_ASSERT_IMPL(a_millis_range, clk, rst, m_tvalid, m_tdata[9:0] < 10'd1000)

  // Input backpressure only appears when the output is stalled.
  `CCR_ASSERT_IMPL(a_ready_stall, clk, rst, !s_tready, m_tvalid && !m_tready)

  // A new result comes from a request that was accepted and then held in the request register.
  `CCR_ASSERT_IMPL(a_out_origin, clk, rst, $rose(m_tvalid), $past(in_xfer, 2))

endmodule

bind calendar_clock_rollover_unit ccr_checker u_ccr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
